FILE: hdl/hrhp_pkg.sv
// Package for the request head parser: field widths, kind and error codes, result type.
// No dependencies.
package hrhp_pkg;
	localparam int QueueDepth = 4;

	typedef enum logic [2:0] {
		KIND_METHOD  = 3'd0,
		KIND_PATH    = 3'd1,
		KIND_VERSION = 3'd2,
		KIND_NAME    = 3'd3,
		KIND_VALUE   = 3'd4,
		KIND_LINEEND = 3'd5,
		KIND_VERDICT = 3'd6
	} kind_t;

	localparam logic [2:0] ERR_NO_END   = 3'd0;
	localparam logic [2:0] ERR_MISSING  = 3'd1;
	localparam logic [2:0] ERR_METHOD   = 3'd2;
	localparam logic [2:0] ERR_EXTRA    = 3'd3;
	localparam logic [2:0] ERR_VERSION  = 3'd4;
	localparam logic [2:0] ERR_NO_COLON = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_request;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] text_byte;
		logic       accepted;
		logic [2:0] error_code;
		logic       last_result;
	} result_t;

	// One byte's worth of results, up to three.
	typedef struct packed {
		logic [1:0] count;
		result_t [2:0] res;
	} group_t;

	function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] p);
		logic [7:0] w [7][7];
		w = '{'{"G","E","T",8'h00,8'h00,8'h00,8'h00},
			'{"P","O","S","T",8'h00,8'h00,8'h00},
			'{"P","U","T",8'h00,8'h00,8'h00,8'h00},
			'{"P","A","T","C","H",8'h00,8'h00},
			'{"D","E","L","E","T","E",8'h00},
			'{"H","E","A","D",8'h00,8'h00,8'h00},
			'{"O","P","T","I","O","N","S"}};
		return (p < 3'd7) ? w[m][p] : 8'd0;
	endfunction

	function automatic logic [3:0] method_len(input logic [2:0] m);
		case (m)
			3'd0: return 4'd3;
			3'd1: return 4'd4;
			3'd2: return 4'd3;
			3'd3: return 4'd5;
			3'd4: return 4'd6;
			3'd5: return 4'd4;
			default: return 4'd7;
		endcase
	endfunction

	function automatic logic [7:0] version_char(input logic [2:0] p);
		case (p)
			3'd0: return "H";
			3'd1: return "T";
			3'd2: return "T";
			3'd3: return "P";
			3'd4: return "/";
			3'd5: return "1";
			3'd6: return ".";
			default: return "1";
		endcase
	endfunction
endpackage

FILE: hdl/hrhp_stream_if.sv
// Valid/ready stream interface with a generic payload.
// Depends on nothing.
interface hrhp_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/hrhp_front.sv
// Front part: parses each byte and produces the group of results it causes.
// Depends on hrhp_pkg.
module hrhp_front import hrhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       end_of_request,
	output group_t     grp
);
	logic [1:0] phase_q, phase_d;
	logic [1:0] tidx_q, tidx_d;
	logic       intok_q, intok_d;
	logic [6:0] mm_q, mm_d;
	logic [3:0] tpos_q, tpos_d;
	logic       vm_q, vm_d, extra_q, extra_d, cr_q, cr_d;
	logic       ls_q, ls_d, colon_q, colon_d, vfirst_q, vfirst_d;

	always_comb begin
		logic [7:0] b;
		logic       consumed, ws, done;
		logic [1:0] n;
		result_t    r [3];
		for (int k = 0; k < 3; k++) r[k] = '0;
		n = 2'd0;
		phase_d = phase_q; tidx_d = tidx_q; intok_d = intok_q; mm_d = mm_q;
		tpos_d = tpos_q; vm_d = vm_q; extra_d = extra_q; cr_d = cr_q;
		ls_d = ls_q; colon_d = colon_q; vfirst_d = vfirst_q;
		consumed = 1'b0;
		ws = 1'b0;
		b = 8'h0d;
		done = phase_q[1];
		for (int pass = 0; pass < 2; pass++) begin
			if (!done && !consumed) begin
				if (pass == 0) begin
					if (!cr_q) continue;
					cr_d = 1'b0;
					b = 8'h0d;
					if (data_byte == 8'h0a) begin
						consumed = 1'b1;
						if (phase_d == 2'd0) begin
							if (intok_d) begin
								if (tidx_d == 2'd0)
									for (int i = 0; i < 7; i++)
										if (method_len(3'(i)) != tpos_d) mm_d[i] = 1'b0;
								if (tidx_d == 2'd2 && tpos_d != 4'd8) vm_d = 1'b0;
								if (tidx_d != 2'd3) tidx_d = tidx_d + 2'd1;
								intok_d = 1'b0;
							end
							if (tidx_d != 2'd3 || mm_d == '0 || extra_d || !vm_d) begin
								r[n].kind = KIND_VERDICT;
								r[n].error_code = (tidx_d != 2'd3) ? ERR_MISSING :
									(mm_d == '0) ? ERR_METHOD : extra_d ? ERR_EXTRA : ERR_VERSION;
								n = n + 2'd1;
								phase_d = 2'd2;
							end else begin
								phase_d = 2'd1; ls_d = 1'b1; colon_d = 1'b0; vfirst_d = 1'b0;
							end
						end else begin
							r[n].kind = (ls_d || !colon_d) ? KIND_VERDICT : KIND_LINEEND;
							r[n].accepted = ls_d;
							r[n].error_code = (!ls_d && !colon_d) ? ERR_NO_COLON : ERR_NO_END;
							n = n + 2'd1;
							if (ls_d || !colon_d) phase_d = 2'd2;
							else begin
								ls_d = 1'b1; colon_d = 1'b0; vfirst_d = 1'b0;
							end
						end
						continue;
					end
				end else begin
					b = data_byte;
					if (b == 8'h0d) begin
						cr_d = 1'b1;
						continue;
					end
				end
				if (phase_d == 2'd0) begin
					ws = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
					if (ws) begin
						if (intok_d) begin
							if (tidx_d == 2'd0)
								for (int i = 0; i < 7; i++)
									if (method_len(3'(i)) != tpos_d) mm_d[i] = 1'b0;
							if (tidx_d == 2'd2 && tpos_d != 4'd8) vm_d = 1'b0;
							if (tidx_d != 2'd3) tidx_d = tidx_d + 2'd1;
							intok_d = 1'b0;
						end
					end else begin
						if (!intok_d) begin
							intok_d = 1'b1; tpos_d = 4'd0;
							if (tidx_d == 2'd3) extra_d = 1'b1;
						end
						if (tidx_d == 2'd0) begin
							for (int i = 0; i < 7; i++)
								if (tpos_d >= method_len(3'(i)) ||
									method_char(3'(i), tpos_d[2:0]) != b) mm_d[i] = 1'b0;
							r[n].kind = KIND_METHOD;
						end else if (tidx_d == 2'd1) begin
							r[n].kind = KIND_PATH;
						end else if (tidx_d == 2'd2) begin
							if (tpos_d[3] || version_char(tpos_d[2:0]) != b) vm_d = 1'b0;
							r[n].kind = KIND_VERSION;
						end
						if (tidx_d != 2'd3) begin
							r[n].text_byte = b;
							n = n + 2'd1;
						end
						if (tpos_d != 4'd15) tpos_d = tpos_d + 4'd1;
					end
				end else if (phase_d == 2'd1) begin
					ls_d = 1'b0;
					if (!colon_d) begin
						if (b == ":") begin
							colon_d = 1'b1; vfirst_d = 1'b1;
						end else begin
							r[n].kind = KIND_NAME; r[n].text_byte = b; n = n + 2'd1;
						end
					end else if (vfirst_d && b == " ") begin
						vfirst_d = 1'b0;
					end else begin
						vfirst_d = 1'b0;
						r[n].kind = KIND_VALUE; r[n].text_byte = b; n = n + 2'd1;
					end
				end
			end
		end
		if (end_of_request && !phase_d[1] && !done) begin
			r[n].kind = KIND_VERDICT;
			r[n].error_code = ERR_NO_END;
			n = n + 2'd1;
		end
		if (n != 2'd0) r[n - 2'd1].last_result = 1'b1;
		grp.count = n;
		grp.res = {r[2], r[1], r[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0; tidx_q <= 2'd0; intok_q <= 1'b0; mm_q <= 7'h7f;
			tpos_q <= 4'd0; vm_q <= 1'b1; extra_q <= 1'b0; cr_q <= 1'b0;
			ls_q <= 1'b1; colon_q <= 1'b0; vfirst_q <= 1'b0;
		end else if (step) begin
			if (end_of_request) begin
				phase_q <= 2'd0; tidx_q <= 2'd0; intok_q <= 1'b0; mm_q <= 7'h7f;
				tpos_q <= 4'd0; vm_q <= 1'b1; extra_q <= 1'b0; cr_q <= 1'b0;
				ls_q <= 1'b1; colon_q <= 1'b0; vfirst_q <= 1'b0;
			end else begin
				phase_q <= phase_d; tidx_q <= tidx_d; intok_q <= intok_d; mm_q <= mm_d;
				tpos_q <= tpos_d; vm_q <= vm_d; extra_q <= extra_d; cr_q <= cr_d;
				ls_q <= ls_d; colon_q <= colon_d; vfirst_q <= vfirst_d;
			end
		end
	end
endmodule

FILE: hdl/hrhp_back.sv
// Back part: a group queue and a drain that hands results out one per handshake.
// Depends on hrhp_pkg.
module hrhp_back import hrhp_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  group_t  grp,
	output logic    has_room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);
	localparam int AW = $clog2(Depth);
	group_t          mem [Depth];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic [1:0]      sub_q;
	logic            pop;
	group_t          head;

	assign head      = mem[rd_q];
	assign has_room  = cnt_q != (AW+1)'(Depth);
	assign out_valid = cnt_q != '0;
	assign out_res   = head.res[sub_q];
	assign pop       = out_valid && out_ready && (sub_q == head.count - 2'd1);

	always_ff @(posedge clk) begin
		if (push && grp.count != 2'd0) mem[wr_q] <= grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
		end else begin
			if (push && grp.count != 2'd0)
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
				sub_q <= '0;
			end else if (out_valid && out_ready) begin
				sub_q <= sub_q + 2'd1;
			end
			cnt_q <= cnt_q + (AW+1)'(push && grp.count != 2'd0) - (AW+1)'(pop);
		end
	end
endmodule

FILE: hdl/http_request_head_parser.sv
// Request head parser top level: byte front end feeding a result queue.
// Depends on hrhp_pkg, hrhp_stream_if, hrhp_front and hrhp_back.
// A byte's results, if any, are written into the group queue as one group when the byte is accepted.
// Throughput: one byte per cycle while the queue has room; results leave one per cycle while out_res is ready.
// A byte causing up to three results holds queue room for all of them in one group slot.
// Reset clears parser state and queue pointers asynchronously.
module http_request_head_parser import hrhp_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input logic clk,
	input logic arst_n,
	hrhp_stream_if.sink   in_req,
	hrhp_stream_if.source out_res
);
	group_t  grp;
	logic    room, step;
	result_t r;

	assign in_req.ready = room;
	assign step = in_req.valid && room;

	hrhp_front u_front (
		.clk, .arst_n, .step,
		.data_byte(in_req.payload.data_byte),
		.end_of_request(in_req.payload.end_of_request),
		.grp
	);

	hrhp_back #(.Depth(Depth)) u_back (
		.clk, .arst_n, .push(step), .grp, .has_room(room),
		.out_valid(out_res.valid), .out_ready(out_res.ready), .out_res(r)
	);
	assign out_res.payload = r;

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_res.valid |-> out_res.payload.kind != 3'd7) else $error("bad kind");
	a_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_res.valid && (out_res.payload.kind == KIND_VERDICT ||
		out_res.payload.kind == KIND_LINEEND) |-> out_res.payload.text_byte == 8'd0)
		else $error("text on non-byte kind");
endmodule

FILE: dv/tb_http_request_head_parser.sv
// Testbench for http_request_head_parser: drives request bytes, predicts the tagged results
// and checks them in order. Depends on hrhp_pkg, hrhp_stream_if and the parser RTL.
class head_scoreboard;
	hrhp_pkg::result_t pending[$];
	int errors;
	int shown;
	bit [1:0] phase;
	bit [1:0] token_index;
	bit inside_token;
	bit [6:0] method_match;
	bit [3:0] token_position;
	bit version_match;
	bit extra_token_seen;
	bit cr_held;
	bit line_start;
	bit colon_seen;
	bit value_first;
	hrhp_pkg::result_t step_res[$];
	string method_words[7] = '{"GET", "POST", "PUT", "PATCH", "DELETE", "HEAD", "OPTIONS"};
	string version_word = "HTTP/1.1";

	function void clear_state();
		phase = 0;
		token_index = 0;
		inside_token = 0;
		method_match = 7'h7f;
		token_position = 0;
		version_match = 1;
		extra_token_seen = 0;
		cr_held = 0;
		line_start = 1;
		colon_seen = 0;
		value_first = 0;
	endfunction

	function new();
		errors = 0;
		shown = 0;
		clear_state();
	endfunction

	function void emit(hrhp_pkg::kind_t k, bit [7:0] t, bit a, bit [2:0] e);
		hrhp_pkg::result_t r;
		r.kind = k;
		r.text_byte = t;
		r.accepted = a;
		r.error_code = e;
		r.last_result = 0;
		if (step_res.size() < 3) step_res.push_back(r);
	endfunction

	function void close_token();
		if (token_index == 0) begin
			for (int i = 0; i < 7; i++)
				if (method_words[i].len() != token_position) method_match[i] = 0;
		end else if (token_index == 2) begin
			if (token_position != 8) version_match = 0;
		end
		if (token_index < 3) token_index++;
		inside_token = 0;
	endfunction

	function void line_byte(bit [7:0] b);
		int p;
		if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0d)) begin
			if (inside_token) close_token();
			return;
		end
		if (!inside_token) begin
			inside_token = 1;
			token_position = 0;
			if (token_index == 3) extra_token_seen = 1;
		end
		p = token_position;
		if (token_index == 0) begin
			for (int i = 0; i < 7; i++)
				if (p >= method_words[i].len() || method_words[i][p] != b) method_match[i] = 0;
			emit(hrhp_pkg::KIND_METHOD, b, 0, 0);
		end else if (token_index == 1) begin
			emit(hrhp_pkg::KIND_PATH, b, 0, 0);
		end else if (token_index == 2) begin
			if (p >= 8 || version_word[p] != b) version_match = 0;
			emit(hrhp_pkg::KIND_VERSION, b, 0, 0);
		end
		if (token_position < 15) token_position++;
	endfunction

	function void line_end();
		bit [2:0] e;
		if (inside_token) close_token();
		if (token_index < 3) e = hrhp_pkg::ERR_MISSING;
		else if (method_match == 0) e = hrhp_pkg::ERR_METHOD;
		else if (extra_token_seen) e = hrhp_pkg::ERR_EXTRA;
		else if (!version_match) e = hrhp_pkg::ERR_VERSION;
		else begin
			phase = 1;
			line_start = 1;
			colon_seen = 0;
			value_first = 0;
			return;
		end
		emit(hrhp_pkg::KIND_VERDICT, 0, 0, e);
		phase = 2;
	endfunction

	function void header_byte(bit [7:0] b);
		line_start = 0;
		if (!colon_seen) begin
			if (b == ":") begin
				colon_seen = 1;
				value_first = 1;
			end else emit(hrhp_pkg::KIND_NAME, b, 0, 0);
		end else if (value_first && b == " ") begin
			value_first = 0;
		end else begin
			value_first = 0;
			emit(hrhp_pkg::KIND_VALUE, b, 0, 0);
		end
	endfunction

	function void close_header_line();
		if (line_start) begin
			emit(hrhp_pkg::KIND_VERDICT, 0, 1, 0);
			phase = 2;
		end else if (!colon_seen) begin
			emit(hrhp_pkg::KIND_VERDICT, 0, 0, hrhp_pkg::ERR_NO_COLON);
			phase = 2;
		end else begin
			emit(hrhp_pkg::KIND_LINEEND, 0, 0, 0);
			line_start = 1;
			colon_seen = 0;
			value_first = 0;
		end
	endfunction

	function void plain(bit [7:0] b);
		if (phase == 0) line_byte(b);
		else if (phase == 1) header_byte(b);
	endfunction

	function void note_request(hrhp_pkg::req_t q);
		bit consumed;
		step_res.delete();
		if (phase < 2) begin
			consumed = 0;
			if (cr_held) begin
				cr_held = 0;
				if (q.data_byte == 8'h0a) begin
					if (phase == 0) line_end();
					else close_header_line();
					consumed = 1;
				end else plain(8'h0d);
			end
			if (!consumed) begin
				if (q.data_byte == 8'h0d) cr_held = 1;
				else plain(q.data_byte);
			end
			if (q.end_of_request && phase < 2)
				emit(hrhp_pkg::KIND_VERDICT, 0, 0, hrhp_pkg::ERR_NO_END);
		end
		if (q.end_of_request) clear_state();
		if (step_res.size() > 0) step_res[step_res.size() - 1].last_result = 1;
		foreach (step_res[i]) pending.push_back(step_res[i]);
	endfunction

	function void check_result(hrhp_pkg::result_t got);
		hrhp_pkg::result_t want;
		if (pending.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("unexpected result %p", got);
			end
			return;
		end
		want = pending.pop_front();
		if (got.kind !== want.kind || got.text_byte !== want.text_byte ||
				got.accepted !== want.accepted || got.error_code !== want.error_code ||
				got.last_result !== want.last_result) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("mismatch: expected %p actual %p", want, got);
			end
		end
	endfunction
endclass

module tb_http_request_head_parser;
	import hrhp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int cycles = 0;
	int send_idle = 11;
	int recv_idle = 59;
	localparam int CycleLimit = 200000;

	hrhp_stream_if #(.payload_t(req_t)) in_req ();
	hrhp_stream_if #(.payload_t(result_t)) out_res ();

	http_request_head_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_req(in_req.sink),
		.out_res(out_res.source)
	);

	head_scoreboard sb = new();
	byte unsigned buffer[$];
	string method_words[7] = '{"GET", "POST", "PUT", "PATCH", "DELETE", "HEAD", "OPTIONS"};

	always #4 clk = ~clk;

	initial begin
		in_req.valid = 0;
		in_req.payload = '0;
		out_res.ready = 0;
	end

	always @(negedge clk) begin
		out_res.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_req.valid && in_req.ready) sb.note_request(in_req.payload);
			if (out_res.valid && out_res.ready) sb.check_result(out_res.payload);
		end
		if (cycles > CycleLimit) begin
			$display("[http_request_head_parser] ERROR");
			$finish;
		end
	end

	task automatic send_byte(input byte unsigned b, input bit last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_req.valid = 0;
			@(negedge clk);
		end
		in_req.valid = 1;
		in_req.payload.data_byte = b;
		in_req.payload.end_of_request = last;
		@(posedge clk);
		while (!in_req.ready) @(posedge clk);
		@(negedge clk);
		in_req.valid = 0;
	endtask

	task automatic send_buffer();
		foreach (buffer[i]) send_byte(buffer[i], i == buffer.size() - 1);
		buffer.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) buffer.push_back(s[i]);
	endtask

	task automatic send_text(input string s);
		add_text(s);
		send_buffer();
	endtask

	function automatic byte unsigned token_char();
		return byte'($urandom_range(33, 126));
	endfunction

	task automatic build_request();
		int n;
		int sel;
		sel = $urandom_range(99);
		if (sel < 15) begin
			n = $urandom_range(1, 12);
			repeat (n) buffer.push_back(byte'($urandom_range(255)));
			return;
		end
		if ($urandom_range(9) < 8) add_text(method_words[$urandom_range(6)]);
		else repeat ($urandom_range(1, 9)) buffer.push_back(token_char());
		buffer.push_back($urandom_range(3) == 0 ? 8'h09 : 8'h20);
		repeat ($urandom_range(1, 6)) buffer.push_back(token_char());
		if ($urandom_range(19) != 0) buffer.push_back(8'h20);
		if ($urandom_range(9) < 8) add_text("HTTP/1.1");
		else repeat ($urandom_range(1, 10)) buffer.push_back(token_char());
		if ($urandom_range(15) == 0) add_text(" x");
		add_text("\r\n");
		repeat ($urandom_range(0, 3)) begin
			repeat ($urandom_range(0, 4)) buffer.push_back(token_char());
			if ($urandom_range(9) != 0) buffer.push_back(":");
			if ($urandom_range(1)) buffer.push_back(" ");
			repeat ($urandom_range(0, 4)) begin
				sel = $urandom_range(9);
				buffer.push_back(sel == 0 ? 8'h0d : sel == 1 ? 8'h0a : token_char());
			end
			add_text("\r\n");
		end
		if ($urandom_range(9) != 0) add_text("\r\n");
		if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) buffer.push_back(token_char());
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(1, buffer.size());
			while (buffer.size() > n) void'(buffer.pop_back());
		end
	endtask

	task automatic random_phase(input int bytes);
		int sent;
		sent = 0;
		while (sent < bytes) begin
			build_request();
			sent += buffer.size();
			send_buffer();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_text("GET /a HTTP/1.1\r\nHost: x\r\nK:v\r\n\r\nzz");
		send_text("OPTIONS\t/p\nHTTP/1.1\r\nA:  b\rc\n\r\n");
		send_text("BREW / HTTP/1.1\r\n");
		send_text("PUT / HTTP/1.1 x\r\n");
		send_text("POST / HTTP/1.0\r\n");
		send_text("DELETE /\r\n");
		send_text("HEAD / HTTP/1.1\r\nnocolon\r\n");
		send_text("PATCH / HTTP/1.1\r\n:\r\n\r");
		send_byte(8'hff, 0);
		send_byte(8'h00, 1);
		send_text("\r\n");
		random_phase(50);
		send_idle = 59;
		recv_idle = 11;
		random_phase(50);
		send_idle = 0;
		recv_idle = 0;
		random_phase(50);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[http_request_head_parser] OK");
		end else begin
			$display("[http_request_head_parser] ERROR");
		end
		$finish;
	end
endmodule
